/* hw/rtl/wavp_pkg.sv */
package wavp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] RATE_RESET = 32'd16000;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = 2;

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID, PH_SZFMT, PH_SZDATA, PH_SZSKIP,
    PH_FMT, PH_SKIP, PH_DATA, PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    ST_SAMPLE    = 4'd0,
    ST_BAD_TAGS  = 4'd1,
    ST_FMT_SHORT = 4'd2,
    ST_NO_FMT    = 4'd3,
    ST_NOT_PCM16 = 4'd4,
    ST_RATE      = 4'd5,
    ST_CHANNELS  = 4'd6,
    ST_PARTIAL   = 4'd7,
    ST_DATA_SHRT = 4'd8,
    ST_NO_DATA   = 4'd9
  } status_t;

  // one result item
  typedef struct packed {
    logic signed [15:0] sample;
    status_t            status;
    logic               last;
  } result_t;

endpackage

/* hw/rtl/wavp_front.sv */
module wavp_front
  import wavp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_vld,
  input  logic [7:0]  data_byte,
  input  logic        end_of_file,
  input  logic [31:0] required_rate,
  output logic        res_vld,
  output result_t     res
);

  phase_t      phase_r, phase_nxt;
  logic [4:0]  field_count_r, field_count_nxt;
  logic [31:0] tag_shift_r, tag_shift_nxt;
  logic [32:0] bytes_left_r, bytes_left_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;
  logic [15:0] format_code_r, format_code_nxt;
  logic [15:0] channel_count_r, channel_count_nxt;
  logic [31:0] declared_rate_r, declared_rate_nxt;
  logic [15:0] sample_bits_r, sample_bits_nxt;
  logic [23:0] frame_hold_r, frame_hold_nxt;
  logic [1:0]  fbi_r, fbi_nxt;

  logic [31:0] shifted;
  logic [31:0] size;
  logic        word_done, fin, have;
  status_t     status;
  logic [15:0] smp;
  logic signed [16:0] lr_sum;
  logic signed [15:0] left_s, right_s;
  logic        is_mono;
  logic [32:0] bl_dec;
  logic        misalign;

  assign shifted = {data_byte, tag_shift_r[31:8]};
  assign size    = shifted;
  assign is_mono = (channel_count_r == 16'd1);
  assign bl_dec  = (bytes_left_r != 33'd0) ? bytes_left_r - 33'd1 : 33'd0;
  // data size must hold whole frames: 2 bytes mono, 4 stereo
  assign misalign = is_mono ? size[0] : (size[1:0] != 2'b00);
  assign left_s  = frame_hold_r[15:0];
  assign right_s = {data_byte, frame_hold_r[23:16]};
  assign lr_sum  = 17'(left_s) + 17'(right_s);

  always_comb begin
    phase_nxt         = phase_r;
    field_count_nxt   = field_count_r;
    tag_shift_nxt     = tag_shift_r;
    bytes_left_nxt    = bytes_left_r;
    fmt_seen_nxt      = fmt_seen_r;
    format_code_nxt   = format_code_r;
    channel_count_nxt = channel_count_r;
    declared_rate_nxt = declared_rate_r;
    sample_bits_nxt   = sample_bits_r;
    frame_hold_nxt    = frame_hold_r;
    fbi_nxt           = fbi_r;
    word_done = 1'b0;
    fin       = 1'b0;
    have      = 1'b0;
    status    = ST_SAMPLE;
    smp       = 16'd0;

    if (byte_vld) begin
      // header words are gathered four bytes at a time
      if (phase_r <= PH_SZSKIP) begin
        tag_shift_nxt = shifted;
        if (field_count_r >= 5'd3) begin
          field_count_nxt = 5'd0;
          word_done = 1'b1;
        end else begin
          field_count_nxt = field_count_r + 5'd1;
        end
      end

      if (word_done) begin
        unique case (phase_r)
          PH_RIFF: begin
            if (shifted == TAG_RIFF) phase_nxt = PH_RSIZE;
            else begin status = ST_BAD_TAGS; fin = 1'b1; end
          end
          PH_RSIZE: phase_nxt = PH_WAVE;
          PH_WAVE: begin
            if (shifted == TAG_WAVE) phase_nxt = PH_ID;
            else begin status = ST_BAD_TAGS; fin = 1'b1; end
          end
          PH_ID: begin
            if (shifted == TAG_FMT)       phase_nxt = PH_SZFMT;
            else if (shifted == TAG_DATA) phase_nxt = PH_SZDATA;
            else                          phase_nxt = PH_SZSKIP;
          end
          PH_SZFMT: begin
            if (size < 32'd16) begin status = ST_FMT_SHORT; fin = 1'b1; end
            else begin
              bytes_left_nxt = {1'b0, size} + 33'(size[0]) - 33'd16;
              phase_nxt = PH_FMT;
            end
          end
          PH_SZSKIP: begin
            bytes_left_nxt = {1'b0, size} + 33'(size[0]);
            phase_nxt = ({1'b0, size} + 33'(size[0]) != 33'd0) ? PH_SKIP : PH_ID;
          end
          default: begin
            if (!fmt_seen_r) status = ST_NO_FMT;
            else if (format_code_r != 16'd1 || sample_bits_r != 16'd16)
              status = ST_NOT_PCM16;
            else if (declared_rate_r != required_rate) status = ST_RATE;
            else if (channel_count_r != 16'd1 && channel_count_r != 16'd2)
              status = ST_CHANNELS;
            else if (misalign) status = ST_PARTIAL;
            else if (size == 32'd0) status = ST_NO_DATA;
            if (status != ST_SAMPLE) fin = 1'b1;
            else begin
              bytes_left_nxt = {1'b0, size};
              frame_hold_nxt = 24'd0;
              fbi_nxt        = 2'd0;
              phase_nxt      = PH_DATA;
            end
          end
        endcase
        have = fin;
      end else if (phase_r == PH_FMT) begin
        // fmt body: capture fields by byte position
        tag_shift_nxt   = shifted;
        field_count_nxt = field_count_r + 5'd1;
        if (field_count_r == 5'd1) format_code_nxt = shifted[31:16];
        else if (field_count_r == 5'd3) channel_count_nxt = shifted[31:16];
        else if (field_count_r == 5'd7) declared_rate_nxt = shifted;
        else if (field_count_r >= 5'd15) begin
          sample_bits_nxt = shifted[31:16];
          field_count_nxt = 5'd0;
          fmt_seen_nxt    = 1'b1;
          phase_nxt = (bytes_left_r != 33'd0) ? PH_SKIP : PH_ID;
        end
      end else if (phase_r == PH_SKIP) begin
        bytes_left_nxt = bl_dec;
        if (bl_dec == 33'd0) phase_nxt = PH_ID;
      end else if (phase_r == PH_DATA) begin
        bytes_left_nxt = bl_dec;
        if ((is_mono && fbi_r == 2'd1) || (!is_mono && fbi_r == 2'd3)) begin
          // truncate toward zero: bias negative odd sums up
          if (is_mono) smp = {data_byte, frame_hold_r[7:0]};
          else smp = 16'((lr_sum + 17'(lr_sum[16] & lr_sum[0])) >>> 1);
          frame_hold_nxt = 24'd0;
          fbi_nxt        = 2'd0;
          have           = 1'b1;
          if (bl_dec == 33'd0) begin fin = 1'b1; phase_nxt = PH_DONE; end
        end else begin
          case (fbi_r)
            2'd0:    frame_hold_nxt[7:0]   = data_byte;
            2'd1:    frame_hold_nxt[15:8]  = data_byte;
            default: frame_hold_nxt[23:16] = data_byte;
          endcase
          fbi_nxt = fbi_r + 2'd1;
        end
      end

      if (fin && status != ST_SAMPLE) begin
        smp = 16'd0;
        phase_nxt = PH_DONE;
      end

      // end of file: report where the file stopped, then rearm
      if (end_of_file) begin
        if (!fin && phase_nxt != PH_DONE) begin
          have = 1'b1;
          fin  = 1'b1;
          smp  = 16'd0;
          if (phase_nxt <= PH_WAVE)     status = ST_BAD_TAGS;
          else if (phase_nxt == PH_FMT) status = ST_FMT_SHORT;
          else if (phase_nxt == PH_DATA) status = ST_DATA_SHRT;
          else                          status = ST_NO_DATA;
        end
        phase_nxt = PH_RIFF;
        field_count_nxt = 5'd0;
        tag_shift_nxt = 32'd0;
        bytes_left_nxt = 33'd0;
        fmt_seen_nxt = 1'b0;
        format_code_nxt = 16'd0;
        channel_count_nxt = 16'd0;
        declared_rate_nxt = 32'd0;
        sample_bits_nxt = 16'd0;
        frame_hold_nxt = 24'd0;
        fbi_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF;
      field_count_r <= 5'd0;
      tag_shift_r <= 32'd0;
      bytes_left_r <= 33'd0;
      fmt_seen_r <= 1'b0;
      format_code_r <= 16'd0;
      channel_count_r <= 16'd0;
      declared_rate_r <= 32'd0;
      sample_bits_r <= 16'd0;
      frame_hold_r <= 24'd0;
      fbi_r <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      field_count_r <= field_count_nxt;
      tag_shift_r <= tag_shift_nxt;
      bytes_left_r <= bytes_left_nxt;
      fmt_seen_r <= fmt_seen_nxt;
      format_code_r <= format_code_nxt;
      channel_count_r <= channel_count_nxt;
      declared_rate_r <= declared_rate_nxt;
      sample_bits_r <= sample_bits_nxt;
      frame_hold_r <= frame_hold_nxt;
      fbi_r <= fbi_nxt;
    end
  end

  assign res_vld    = byte_vld && have;
  assign res.sample = smp;
  assign res.status = status;
  assign res.last   = fin;

endmodule

/* hw/rtl/wavp_queue.sv */
module wavp_queue
  import wavp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  result_t wr_data,
  output logic    almost_full,
  input  logic    rd_en,
  output logic    empty,
  output result_t rd_data
);

  result_t      mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  // result queue between parser and consumer
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(wr_en) - (QAW+1)'(rd_en);
    end
  end

  // stop input while one free slot remains
  assign almost_full = (cnt_r >= (QAW+1)'(QDEPTH - 1));
  assign empty       = (cnt_r == '0);
  assign rd_data     = mem_r[rp_r];

endmodule

/* hw/rtl/wav_pcm16_stream_parser_core.sv */
// WAV PCM16 stream parser.
// Input channel: one file byte per item on in_data_byte, in_end_of_file set on
// the final byte. An item is taken when in_push is high and in_full is low.
// Result channel: out_sample/out_status/out_last show the oldest result while
// out_empty is low; out_pop takes it. out_last marks the final result of a file.
// Config: cfg_required_rate is written when cfg_valid and cfg_ready are high;
// cfg_ready is always high. Write only while the block is idle.
// Throughput: one byte per cycle while in_full is low. A byte that makes a
// result is parsed in the cycle it is taken and is readable the next cycle.
// Results go into a 4-entry queue; in_full rises once three entries are held,
// so a stalled consumer stops the input after at most three pending results.
// Reset (rst_n low, synchronous) clears the parser to wait for the RIFF tag,
// empties the queue and sets the required rate to 16000.
module wav_pcm16_stream_parser_core
  import wavp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_end_of_file,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [15:0] out_sample,
  output logic [3:0]         out_status,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_required_rate
);

  logic [31:0] rate_r;
  logic        acc, res_vld, qfull;
  result_t     res, qout;

  // config register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) rate_r <= RATE_RESET;
    else if (cfg_valid) rate_r <= cfg_required_rate;
  end

  assign in_full = qfull;
  assign acc     = in_push && !qfull;

  wavp_front u_front (
    .clk, .rst_n,
    .byte_vld(acc), .data_byte(in_data_byte), .end_of_file(in_end_of_file),
    .required_rate(rate_r), .res_vld, .res
  );

  wavp_queue u_queue (
    .clk, .rst_n,
    .wr_en(res_vld), .wr_data(res), .almost_full(qfull),
    .rd_en(out_pop && !out_empty), .empty(out_empty), .rd_data(qout)
  );

  assign out_sample = qout.sample;
  assign out_status = qout.status;
  assign out_last   = qout.last;

endmodule
